@@ rtl/isc_pkg.sv @@
// Shared types and constants of the intermittent sprayer controller.
package isc_pkg;

  localparam int unsigned InDataW  = 72;
  localparam int unsigned OutDataW = 16;
  localparam int unsigned KindW    = 4;
  localparam int unsigned AddrW    = 5;
  localparam int unsigned PctW     = 7;
  localparam int unsigned CntW     = $clog2(PctW);
  localparam int unsigned RemW     = 32 + PctW;
  localparam int unsigned DvsW     = 32 + PctW - 1;

  localparam logic [CntW-1:0] DivLast = CntW'(PctW - 1);

  localparam logic [1:0] MODE_MANUAL       = 2'd0;
  localparam logic [1:0] MODE_INTERMITTENT = 2'd1;
  localparam logic [1:0] MODE_CONTINUOUS   = 2'd2;
  localparam logic [1:0] MODE_INVALID      = 2'd3;

  localparam logic [1:0] CH_LEFT   = 2'd0;
  localparam logic [1:0] CH_CENTER = 2'd1;
  localparam logic [1:0] CH_RIGHT  = 2'd2;
  localparam logic [1:0] CH_NONE   = 2'd3;

  localparam logic [PctW-1:0] FULL_PERCENT = 7'd100;
  localparam logic [31:0]     PHASE_RESET  = 32'd1000;

  typedef enum logic [KindW-1:0] {
    KIND_TICK         = 4'd0,
    KIND_SET_MODE     = 4'd1,
    KIND_CYCLE_MODE   = 4'd2,
    KIND_SET_ALL      = 4'd3,
    KIND_TOGGLE_CH    = 4'd4,
    KIND_SET_ARMED    = 4'd5,
    KIND_TOGGLE_ARMED = 4'd6,
    KIND_SET_CONT     = 4'd7,
    KIND_RESET        = 4'd8
  } kind_e;

  typedef enum logic [2:0] {
    REG_TRIGGER  = 3'd0,
    REG_ON_TIME  = 3'd1,
    REG_OFF_TIME = 3'd2,
    REG_ON_DIST  = 3'd3,
    REG_OFF_DIST = 3'd4
  } reg_e;

  typedef struct packed {
    logic        trig;
    logic [31:0] on_time;
    logic [31:0] off_time;
    logic [31:0] on_dist;
    logic [31:0] off_dist;
  } cfg_t;

  typedef struct packed {
    logic take;
    logic scale;
    logic div_step;
    logic div_last;
    logic out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic need_div;
  } dp_sts_t;

endpackage

@@ rtl/isc_ctrl.sv @@
// Sequencer: accepts a transaction, runs the percent divider, loads the output register.
module isc_ctrl import isc_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  input  dp_sts_t sts_i,
  output dp_cmd_t cmd_o
);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_SCALE = 4'b0010,
    ST_DIV   = 4'b0100,
    ST_LOAD  = 4'b1000
  } state_e;

  state_e          state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            ovalid_q, ovalid_d;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.take = 1'b1;
          state_d    = sts_i.need_div ? ST_SCALE : ST_LOAD;
        end
      end
      ST_SCALE: begin
        cmd_o.scale = 1'b1;
        cnt_d       = '0;
        state_d     = ST_DIV;
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        cnt_d          = cnt_q + 1'b1;
        if (cnt_q == DivLast) begin
          cmd_o.div_last = 1'b1;
          state_d        = ST_LOAD;
        end
      end
      ST_LOAD: begin
        // wait for the output register to drain
        if (!ovalid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    ovalid_d = ovalid_q;
    if (cmd_o.out_load) begin
      ovalid_d = 1'b1;
    end else if (out_ready_i) begin
      ovalid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      cnt_q    <= '0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      ovalid_q <= ovalid_d;
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = ovalid_q;

endmodule

@@ rtl/isc_dpath.sv @@
// Datapath: mode and phase state, relay drive, serial percent divider, output register.
module isc_dpath import isc_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cfg_t                cfg_i,
  input  dp_cmd_t             cmd_i,
  output dp_sts_t             sts_o,
  input  logic [KindW-1:0]    kind_i,
  input  logic [InDataW-1:0]  data_i,
  output logic [OutDataW-1:0] data_o
);

  logic [31:0] now, odo;
  logic [1:0]  mode_val, chan;
  logic [2:0]  lcr;
  logic        level;
  kind_e       kind;

  assign now      = data_i[31:0];
  assign odo      = data_i[63:32];
  assign mode_val = data_i[65:64];
  assign chan     = data_i[67:66];
  assign lcr      = data_i[70:68];
  assign level    = data_i[71];
  assign kind     = kind_e'(kind_i);

  logic [1:0]          mode_q, mode_d;
  logic [2:0]          wanted_q, wanted_d;
  logic                armed_q, armed_d;
  logic                phase_q, phase_d;
  logic                ovr_q, ovr_d;
  logic [PctW-1:0]     prog_q, prog_d;
  logic [31:0]         start_q, start_d;
  logic [31:0]         lastodo_q, lastodo_d;
  logic [31:0]         pdist_q, pdist_d;
  logic [2:0]          relay_q, relay_d;
  logic [RemW-1:0]     rem_q, rem_d;
  logic [DvsW-1:0]     dvs_q, dvs_d;
  logic [PctW-2:0]     quo_q, quo_d;
  logic [OutDataW-1:0] out_q, out_d;

  logic [31:0] len, el, delta, num;
  logic [32:0] acc;
  logic        tog, adv, ge;
  logic        chg, lvl;
  logic [1:0]  tgt;

  // phase arithmetic, evaluated against the state before the transaction
  always_comb begin
    if (cfg_i.trig) begin
      len = phase_q ? cfg_i.on_dist : cfg_i.off_dist;
    end else begin
      len = phase_q ? cfg_i.on_time : cfg_i.off_time;
    end
    el    = now - start_q;
    delta = odo - lastodo_q;
    acc   = {1'b0, pdist_q} + {1'b0, delta};
    tog   = cfg_i.trig ? (acc >= {1'b0, len}) : (el >= len);
    num   = cfg_i.trig ? acc[31:0] : el;
    adv   = (kind == KIND_TICK) && (mode_q == MODE_INTERMITTENT) && armed_q;
    sts_o.need_div = adv && (len != '0) && !tog;
    ge    = (rem_q >= {1'b0, dvs_q});
  end

  always_comb begin
    mode_d    = mode_q;
    wanted_d  = wanted_q;
    armed_d   = armed_q;
    phase_d   = phase_q;
    ovr_d     = ovr_q;
    prog_d    = prog_q;
    start_d   = start_q;
    lastodo_d = lastodo_q;
    pdist_d   = pdist_q;
    relay_d   = relay_q;
    rem_d     = rem_q;
    dvs_d     = dvs_q;
    quo_d     = quo_q;
    out_d     = out_q;
    chg       = 1'b0;
    tgt       = mode_q;
    lvl       = 1'b0;

    if (cmd_i.take) begin
      rem_d = {{(RemW-32){1'b0}}, num};
      dvs_d = {len, {(PctW-1){1'b0}}};

      case (kind)
        KIND_SET_MODE: begin
          chg = (mode_val != MODE_INVALID);
          tgt = mode_val;
        end
        KIND_CYCLE_MODE: begin
          chg = 1'b1;
          case (mode_q)
            MODE_MANUAL:       tgt = MODE_INTERMITTENT;
            MODE_INTERMITTENT: tgt = MODE_CONTINUOUS;
            default:           tgt = MODE_MANUAL;
          endcase
        end
        KIND_SET_ARMED, KIND_TOGGLE_ARMED: begin
          chg = 1'b1;
          tgt = MODE_INTERMITTENT;
        end
        KIND_SET_CONT: begin
          chg = 1'b1;
          tgt = MODE_CONTINUOUS;
        end
        default: chg = 1'b0;
      endcase

      if (chg && (tgt != mode_q)) begin
        if (mode_q == MODE_INTERMITTENT) begin
          armed_d = 1'b0;
          phase_d = 1'b0;
          prog_d  = '0;
        end
        mode_d = tgt;
        if (tgt == MODE_INTERMITTENT) begin
          start_d   = now;
          lastodo_d = odo;
          pdist_d   = '0;
          phase_d   = 1'b1;
          prog_d    = '0;
        end
        ovr_d = 1'b0;
      end

      case (kind)
        KIND_TICK: begin
          if (mode_q == MODE_INTERMITTENT) begin
            if (!armed_q) begin
              wanted_d = '0;
            end else begin
              if (cfg_i.trig) begin
                lastodo_d = odo;
                pdist_d   = tog ? 32'd0 : acc[31:0];
              end else if (tog) begin
                start_d = now;
              end
              if (tog) begin
                phase_d = ~phase_q;
              end
              if (len == '0) begin
                prog_d = FULL_PERCENT;
              end else if (tog) begin
                prog_d = '0;
              end
            end
          end
          if ((mode_q == MODE_INTERMITTENT) && armed_q) begin
            // override freezes the relays
            if (!ovr_q) begin
              relay_d = phase_d ? wanted_d : 3'b000;
            end
          end else begin
            relay_d = wanted_d;
          end
        end
        KIND_SET_ALL: begin
          wanted_d = lcr;
          if (mode_q == MODE_INTERMITTENT) begin
            ovr_d = 1'b1;
          end
        end
        KIND_TOGGLE_CH: begin
          case (chan)
            CH_LEFT:   wanted_d[0] = ~wanted_q[0];
            CH_CENTER: wanted_d[1] = ~wanted_q[1];
            CH_RIGHT:  wanted_d[2] = ~wanted_q[2];
            default:   wanted_d    = wanted_q;
          endcase
          if ((chan != CH_NONE) && (mode_q == MODE_INTERMITTENT)) begin
            ovr_d = 1'b1;
          end
        end
        KIND_SET_ARMED, KIND_TOGGLE_ARMED: begin
          lvl     = (kind == KIND_SET_ARMED) ? level : ~armed_q;
          armed_d = lvl;
          if (!lvl) begin
            phase_d  = 1'b0;
            prog_d   = '0;
            wanted_d = '0;
          end else begin
            start_d   = now;
            lastodo_d = odo;
            pdist_d   = '0;
            phase_d   = 1'b1;
            prog_d    = '0;
            ovr_d     = 1'b0;
          end
        end
        KIND_SET_CONT: begin
          wanted_d = lcr;
        end
        KIND_RESET: begin
          mode_d    = MODE_MANUAL;
          wanted_d  = '0;
          armed_d   = 1'b0;
          phase_d   = 1'b0;
          prog_d    = '0;
          ovr_d     = 1'b0;
          lastodo_d = '0;
          pdist_d   = '0;
          relay_d   = '0;
        end
        // mode requests were handled above; unused kinds change nothing
        default: ;
      endcase
    end

    // elapsed * 100 as shifts and adds
    if (cmd_i.scale) begin
      rem_d = {rem_q[RemW-7:0], 6'b0} + {rem_q[RemW-6:0], 5'b0} + {rem_q[RemW-3:0], 2'b0};
    end

    // one restoring quotient bit per step, most significant first
    if (cmd_i.div_step) begin
      if (ge) begin
        rem_d = rem_q - {1'b0, dvs_q};
      end
      dvs_d = dvs_q >> 1;
      quo_d = {quo_q[PctW-3:0], ge};
      if (cmd_i.div_last) begin
        prog_d = {quo_q, ge};
      end
    end

    if (cmd_i.out_load) begin
      out_d = {1'b0, ovr_q, prog_q, phase_q, armed_q, mode_q, relay_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= MODE_MANUAL;
      wanted_q  <= '0;
      armed_q   <= 1'b0;
      phase_q   <= 1'b0;
      ovr_q     <= 1'b0;
      prog_q    <= '0;
      start_q   <= '0;
      lastodo_q <= '0;
      pdist_q   <= '0;
      relay_q   <= '0;
    end else begin
      mode_q    <= mode_d;
      wanted_q  <= wanted_d;
      armed_q   <= armed_d;
      phase_q   <= phase_d;
      ovr_q     <= ovr_d;
      prog_q    <= prog_d;
      start_q   <= start_d;
      lastodo_q <= lastodo_d;
      pdist_q   <= pdist_d;
      relay_q   <= relay_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvs_q <= dvs_d;
    quo_q <= quo_d;
    out_q <= out_d;
  end

  assign data_o = out_q;

endmodule

@@ rtl/intermittent_sprayer_controller_unit.sv @@
// Top level of the intermittent sprayer controller: register port, sequencer and datapath.
// Each input transaction (tick or button event) yields exactly one status transaction.
// A tick in armed intermittent mode whose phase runs on goes through acceptance, the
// scaling of the elapsed amount by 100, the restoring divider that forms the seven-bit
// progress percent one bit per cycle and the load of the result; every other transaction
// goes from acceptance straight to the load. The next transaction is accepted while a
// result still waits in the output register; a result that finds that register full
// waits until it drains. Configuration registers sit at byte addresses 0, 4, 8, 12 and 16;
// the user must write them only while no transaction is in flight; it is not enforced.
module intermittent_sprayer_controller_unit import isc_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // now_ms[31:0], total_distance_mm[63:32], mode_value[65:64], channel[67:66],
  // left_on[68], center_on[69], right_on[70], level[71]
  input  logic [InDataW-1:0]  s_axis_tdata,
  // kind[3:0]
  input  logic [KindW-1:0]    s_axis_tuser,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // relay_left[0], relay_center[1], relay_right[2], mode_now[4:3], armed[5],
  // phase_on[6], progress_percent[13:7], override_on[14], zero[15]
  output logic [OutDataW-1:0] m_axis_tdata,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [AddrW-1:0]    paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  cfg_t    cfg_q, cfg_d;
  reg_e    reg_idx;
  logic    wr_en;
  dp_cmd_t cmd;
  dp_sts_t sts;

  assign pready  = 1'b1;
  assign reg_idx = reg_e'(paddr[AddrW-1:2]);
  assign wr_en   = psel && penable && pwrite && pready;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (reg_idx)
        REG_TRIGGER:  cfg_d.trig     = pwdata[0];
        REG_ON_TIME:  cfg_d.on_time  = pwdata;
        REG_OFF_TIME: cfg_d.off_time = pwdata;
        REG_ON_DIST:  cfg_d.on_dist  = pwdata;
        REG_OFF_DIST: cfg_d.off_dist = pwdata;
        default:      cfg_d          = cfg_q;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_TRIGGER:  prdata = {31'b0, cfg_q.trig};
      REG_ON_TIME:  prdata = cfg_q.on_time;
      REG_OFF_TIME: prdata = cfg_q.off_time;
      REG_ON_DIST:  prdata = cfg_q.on_dist;
      REG_OFF_DIST: prdata = cfg_q.off_dist;
      default:      prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.trig     <= 1'b0;
      cfg_q.on_time  <= PHASE_RESET;
      cfg_q.off_time <= PHASE_RESET;
      cfg_q.on_dist  <= PHASE_RESET;
      cfg_q.off_dist <= PHASE_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  isc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  isc_dpath u_dpath (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_q),
    .cmd_i  (cmd),
    .sts_o  (sts),
    .kind_i (s_axis_tuser),
    .data_i (s_axis_tdata),
    .data_o (m_axis_tdata)
  );

endmodule

@@ rtl/isc_chk.sv @@
// Port-level checks of the sprayer controller and their attachment to the top level.
module isc_chk import isc_pkg::*; (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                s_axis_tvalid,
  input logic                s_axis_tready,
  input logic                m_axis_tvalid,
  input logic                m_axis_tready,
  input logic [OutDataW-1:0] m_axis_tdata
);

  // one transaction in flight: ready drops right after acceptance
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input accepted while a transaction is in flight");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("stalled result changed or dropped");

  a_pct_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[13:7] <= FULL_PERCENT))
    else $error("progress percent above full");

  a_mode_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[4:3] != MODE_INVALID))
    else $error("reported mode out of range");

  a_ovr_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (m_axis_tdata[14] || m_axis_tdata[6] || m_axis_tdata[5]))
      |-> (m_axis_tdata[4:3] == MODE_INTERMITTENT))
    else $error("override, phase or armed reported outside intermittent mode");

endmodule

bind intermittent_sprayer_controller_unit isc_chk u_isc_chk (.*);
